// ===== rtl/swdc_pkg.sv =====
// ============================================================================
// swdc_pkg
// Types, sizes and helpers shared by the sliding-window DC gain conditioner.
// ============================================================================
package swdc_pkg;

    localparam int WINDOW_LEN = 16000;
    localparam int STRIDE_LEN = 4000;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 7;
    localparam int IDX_W    = 14;
    localparam int ADDR_W   = $clog2(WINDOW_LEN);
    localparam int CNT_W    = $clog2(WINDOW_LEN + 1);
    localparam int STRIDE_W = $clog2(STRIDE_LEN + 1);
    localparam int POS_W    = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
    localparam int SUM_W    = SAMPLE_W + CNT_W;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 2;
    localparam int SQ_W     = 2 * SAMPLE_W - 1;
    localparam int SUMSQ_W  = SQ_W + CNT_W;

    // The window sum magnitude stays below 2^MAG_W, so a reciprocal rounded up
    // at this shift gives the exact floor of the mean.
    localparam int MAG_W       = SUM_W - 1;
    localparam int RECIP_SHIFT = MAG_W + CNT_W;
    localparam int RECIP_W     = RECIP_SHIFT - CNT_W + 2;
    localparam int RPROD_W     = MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DC_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    localparam int ROOT_SQ_W  = 2 * SAMPLE_W;
    localparam int ROOT_CMP_W = ROOT_SQ_W + CNT_W;
    localparam logic [SAMPLE_W-1:0] ROOT_FIRST_BIT = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(8);

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_MUL,
        ST_READ_CLIP,
        ST_SUM,
        ST_DC_DIV,
        ST_COND,
        ST_SQRT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic signed [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]           index;
    } in_item_t;

    typedef struct packed {
        logic                       window_ready;
        logic signed [SAMPLE_W-1:0] feature;
        logic signed [SAMPLE_W-1:0] dc_level;
        logic signed [SAMPLE_W-1:0] min_level;
        logic signed [SAMPLE_W-1:0] max_level;
        logic [SAMPLE_W-1:0]        rms_level;
    } out_item_t;

    // Saturate a gain product to the signed 16-bit range.
    function automatic logic signed [SAMPLE_W-1:0] clip16(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi_lim;
        logic signed [PROD_W-1:0] lo_lim;
        hi_lim = PROD_W'(32767);
        lo_lim = -PROD_W'(32768);
        if (v > hi_lim)
        begin
            return 16'sh7FFF;
        end
        else if (v < lo_lim)
        begin
            return 16'sh8000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== rtl/sliding_window_dc_gain_conditioner.sv =====
// ============================================================================
// sliding_window_dc_gain_conditioner
// Rolling audio window with DC removal, gain, clipping and level statistics.
// ============================================================================
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_item  (cmd, sample, index)
//  res      output     res_valid/res_stall  res_item (ready, feature, levels)
//  cfg      input      cfg_wr_en            cfg_wr_data (gain)
//
// One item is worked on at a time. A plain push, restart or idle command passes
// through ST_FINISH only; a read first passes a multiply and a clip state.
// A push that closes a window scans the RAM twice (sum, then condition), plus a
// reciprocal multiplication for the mean and a 16-step square root search with
// a squaring phase and a compare phase per step.
// Reset is asynchronous; the window RAM is not cleared. A stalled result sits
// in the output register while the next item is already taken and processed.
//
module sliding_window_dc_gain_conditioner (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  swdc_pkg::in_item_t         in_item,
    output logic                       res_valid,
    input  logic                       res_stall,
    output swdc_pkg::out_item_t        res_item,
    input  logic                       cfg_wr_en,
    input  logic [swdc_pkg::GAIN_W-1:0] cfg_wr_data
);

    import swdc_pkg::*;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]          wp_reg;
    logic [CNT_W-1:0]           prime_cnt_reg;
    logic                       primed_reg;
    logic [STRIDE_W-1:0]        stride_cnt_reg;
    logic signed [SAMPLE_W-1:0] dc_reg;
    logic signed [SAMPLE_W-1:0] min_reg, max_reg;
    logic [SAMPLE_W-1:0]        rms_reg;
    logic [GAIN_W-1:0]          gain_reg, gain_lat_reg;

    logic                       ready_reg;
    logic                       idx_ok_reg;
    logic signed [SAMPLE_W-1:0] feat_reg;

    logic [CNT_W-1:0]           scan_cnt_reg;
    logic                       rd_vld_reg, p_vld_reg, v_vld_reg, s_vld_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] v_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [SUMSQ_W-1:0]         sumsq_reg;
    logic                       dc_neg_reg;
    logic [MAG_W-1:0]           dc_x_reg;

    logic [SAMPLE_W-1:0]        root_reg, root_bit_reg;
    logic                       root_phase_reg;
    logic [ROOT_SQ_W-1:0]       root_sq_reg;

    logic                       res_valid_reg;
    out_item_t                  res_item_reg;

    // RAM controls
    logic                       ram_we, ram_re;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [SAMPLE_W-1:0]        ram_rdata;

    logic                       accept, close_now, scan_issue, scan_done, cond_done, fin_load;
    logic [POS_W-1:0]           pos_sum;
    logic [ADDR_W-1:0]          rd_pos;
    logic                       idx_in_range;
    logic [CNT_W:0]             prime_inc;
    logic [STRIDE_W:0]          stride_inc;
    logic signed [PROD_W-1:0]   cond_prod;
    logic signed [SAMPLE_W:0]   centered;
    logic [SUM_W-1:0]           sum_abs;
    logic [RPROD_W-1:0]         dc_prod;
    logic [SAMPLE_W:0]          dc_mag;
    logic [SAMPLE_W-1:0]        root_try;
    logic                       root_fits;

    swdc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_LEN)
    ) u_window_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data (in_item.sample),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign accept       = in_valid && (state_reg == ST_IDLE);
    assign prime_inc    = {1'b0, prime_cnt_reg} + 1'b1;
    assign stride_inc   = {1'b0, stride_cnt_reg} + 1'b1;
    assign close_now    = primed_reg ? (stride_inc >= (STRIDE_W+1)'(STRIDE_LEN))
                                     : (prime_inc >= (CNT_W+1)'(WINDOW_LEN));
    assign idx_in_range = POS_W'(in_item.index) < POS_W'(WINDOW_LEN);
    assign pos_sum      = POS_W'(wp_reg) + POS_W'(in_item.index);
    assign rd_pos       = (pos_sum >= POS_W'(WINDOW_LEN)) ? ADDR_W'(pos_sum - POS_W'(WINDOW_LEN))
                                                          : ADDR_W'(pos_sum);
    assign scan_issue   = scan_cnt_reg < CNT_W'(WINDOW_LEN);
    assign scan_done    = !scan_issue && !rd_vld_reg;
    assign cond_done    = scan_done && !p_vld_reg && !v_vld_reg && !s_vld_reg;

    assign centered  = {ram_rdata[SAMPLE_W-1], ram_rdata} - {dc_reg[SAMPLE_W-1], dc_reg};
    assign cond_prod = PROD_W'(centered) * $signed({1'b0, gain_lat_reg});

    assign sum_abs   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign dc_prod   = dc_x_reg * DC_RECIP;
    assign dc_mag    = dc_prod[RECIP_SHIFT +: (SAMPLE_W + 1)];

    // A trial root fits when its square times the window length stays within
    // the sum of squares.
    assign root_try  = root_reg | root_bit_reg;
    assign root_fits = (ROOT_CMP_W'(root_sq_reg) * ROOT_CMP_W'(WINDOW_LEN))
                       <= ROOT_CMP_W'(sumsq_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (cmd_t'(in_item.cmd))
                        CMD_PUSH:    state_next = close_now ? ST_SUM : ST_FINISH;
                        CMD_READ:    state_next = ST_READ_MUL;
                        default:     state_next = ST_FINISH;
                    endcase
                end
            end
            ST_READ_MUL:  state_next = ST_READ_CLIP;
            ST_READ_CLIP: state_next = ST_FINISH;
            ST_SUM:       if (scan_done) state_next = ST_DC_DIV;
            ST_DC_DIV:    state_next = ST_COND;
            ST_COND:      if (cond_done) state_next = ST_SQRT;
            ST_SQRT:      if (root_bit_reg == '0) state_next = ST_FINISH;
            ST_FINISH:    if (!res_valid_reg || !res_stall) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        ram_we    = accept && (in_item.cmd == CMD_PUSH);
        ram_re    = (accept && (in_item.cmd == CMD_READ) && idx_in_range)
                    || (((state_reg == ST_SUM) || (state_reg == ST_COND)) && scan_issue);
        ram_raddr = (state_reg == ST_IDLE) ? rd_pos : scan_cnt_reg[ADDR_W-1:0];
        fin_load  = (state_reg == ST_FINISH) && (!res_valid_reg || !res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            prime_cnt_reg  <= '0;
            primed_reg     <= 1'b0;
            stride_cnt_reg <= '0;
            dc_reg         <= '0;
            min_reg        <= '0;
            max_reg        <= '0;
            rms_reg        <= '0;
            gain_reg       <= GAIN_RESET;
            gain_lat_reg   <= GAIN_RESET;
            ready_reg      <= 1'b0;
            idx_ok_reg     <= 1'b0;
            feat_reg       <= '0;
            scan_cnt_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            p_vld_reg      <= 1'b0;
            v_vld_reg      <= 1'b0;
            s_vld_reg      <= 1'b0;
            sum_reg        <= '0;
            prod_reg       <= '0;
            v_reg          <= '0;
            sq_reg         <= '0;
            sumsq_reg      <= '0;
            dc_neg_reg     <= 1'b0;
            dc_x_reg       <= '0;
            root_reg       <= '0;
            root_bit_reg   <= '0;
            root_phase_reg <= 1'b0;
            root_sq_reg    <= '0;
            res_valid_reg  <= 1'b0;
            res_item_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                gain_reg <= cfg_wr_data;
            end

            rd_vld_reg <= ram_re && (state_reg != ST_IDLE);

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        ready_reg  <= 1'b0;
                        feat_reg   <= '0;
                        idx_ok_reg <= idx_in_range;
                        case (cmd_t'(in_item.cmd))
                            CMD_PUSH:
                            begin
                                wp_reg <= (wp_reg == ADDR_W'(WINDOW_LEN - 1)) ? '0 : wp_reg + 1'b1;
                                if (!primed_reg)
                                begin
                                    prime_cnt_reg <= prime_inc[CNT_W-1:0];
                                    if (close_now)
                                    begin
                                        primed_reg     <= 1'b1;
                                        stride_cnt_reg <= '0;
                                    end
                                end
                                else
                                begin
                                    stride_cnt_reg <= close_now ? '0 : stride_inc[STRIDE_W-1:0];
                                end
                                if (close_now)
                                begin
                                    ready_reg    <= 1'b1;
                                    gain_lat_reg <= gain_reg;
                                    scan_cnt_reg <= '0;
                                    sum_reg      <= '0;
                                end
                            end
                            CMD_RESTART:
                            begin
                                prime_cnt_reg  <= '0;
                                primed_reg     <= 1'b0;
                                stride_cnt_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_READ_MUL:
                begin
                    prod_reg <= cond_prod;
                end
                ST_READ_CLIP:
                begin
                    feat_reg <= idx_ok_reg ? clip16(prod_reg) : '0;
                end
                ST_SUM:
                begin
                    if (scan_issue)
                    begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                    if (rd_vld_reg)
                    begin
                        sum_reg <= sum_reg + SUM_W'(signed'(ram_rdata));
                    end
                    if (scan_done)
                    begin
                        dc_neg_reg <= sum_reg[SUM_W-1];
                        dc_x_reg   <= sum_abs[MAG_W-1:0];
                    end
                end
                ST_DC_DIV:
                begin
                    // Truncation toward zero: divide the magnitude, then restore the sign.
                    dc_reg       <= dc_neg_reg ? SAMPLE_W'(-dc_mag) : SAMPLE_W'(dc_mag);
                    scan_cnt_reg <= '0;
                    sumsq_reg    <= '0;
                    min_reg      <= 16'sh7FFF;
                    max_reg      <= 16'sh8000;
                end
                ST_COND:
                begin
                    if (scan_issue)
                    begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                    p_vld_reg <= rd_vld_reg;
                    v_vld_reg <= p_vld_reg;
                    s_vld_reg <= v_vld_reg;
                    prod_reg  <= cond_prod;
                    v_reg     <= clip16(prod_reg);
                    sq_reg    <= SQ_W'(v_reg * v_reg);
                    if (v_vld_reg)
                    begin
                        if (v_reg < min_reg)
                        begin
                            min_reg <= v_reg;
                        end
                        if (v_reg > max_reg)
                        begin
                            max_reg <= v_reg;
                        end
                    end
                    if (s_vld_reg)
                    begin
                        sumsq_reg <= sumsq_reg + SUMSQ_W'(sq_reg);
                    end
                    if (cond_done)
                    begin
                        root_reg       <= '0;
                        root_bit_reg   <= ROOT_FIRST_BIT;
                        root_phase_reg <= 1'b0;
                    end
                end
                ST_SQRT:
                begin
                    if (root_bit_reg != '0)
                    begin
                        if (!root_phase_reg)
                        begin
                            root_sq_reg    <= root_try * root_try;
                            root_phase_reg <= 1'b1;
                        end
                        else
                        begin
                            if (root_fits)
                            begin
                                root_reg <= root_try;
                            end
                            root_bit_reg   <= root_bit_reg >> 1;
                            root_phase_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        rms_reg <= root_reg;
                    end
                end
                default:
                begin
                end
            endcase

            // Output register: a transfer frees it, a finished item fills it.
            if (fin_load)
            begin
                res_valid_reg             <= 1'b1;
                res_item_reg.window_ready <= ready_reg;
                res_item_reg.feature      <= feat_reg;
                res_item_reg.dc_level     <= dc_reg;
                res_item_reg.min_level    <= min_reg;
                res_item_reg.max_level    <= max_reg;
                res_item_reg.rms_level    <= rms_reg;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    a_minmax_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.min_level <= res_item.max_level))
        else $error("min level above max level");

    a_rms_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.rms_level <= 16'd32768))
        else $error("rms level out of range");

    a_scan_addr: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (POS_W'(ram_raddr) < POS_W'(WINDOW_LEN)))
        else $error("window RAM read beyond depth");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE) && !rd_vld_reg)
        else $error("window RAM written during a scan");

endmodule

// ===== rtl/swdc_ram.sv =====
// ============================================================================
// swdc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module swdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
